@@ rtl/alr_pkg.sv @@
`default_nettype none

package alr_pkg;

	localparam int COORD_INT_BITS     = 12;
	localparam int COORD_FRAC_BITS    = 4;
	localparam int GRADIENT_FRAC_BITS = 16;
	localparam int ALPHA_BITS         = 8;

	localparam int COORD_W     = COORD_INT_BITS + COORD_FRAC_BITS;
	localparam int MAJOR_W     = COORD_INT_BITS + 1;
	localparam int GRAD_W      = GRADIENT_FRAC_BITS + 2;
	localparam int QUO_W       = GRADIENT_FRAC_BITS + 1;
	localparam int NUM_W       = COORD_W + GRADIENT_FRAC_BITS;
	localparam int SCALE_SH    = GRADIENT_FRAC_BITS - COORD_FRAC_BITS;
	localparam int MINOR_W     = COORD_W + SCALE_SH + 2;
	localparam int MINOR_INT_W = MINOR_W - GRADIENT_FRAC_BITS;
	localparam int GAP_W       = COORD_FRAC_BITS + 1;
	localparam int PROD_W      = GRAD_W + GAP_W + 1;
	localparam int DIV_CNT_W   = $clog2(QUO_W + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [GAP_W-1:0] ONE_C = GAP_W'(1 << COORD_FRAC_BITS);
	localparam logic signed [GRAD_W-1:0] ONE_G = GRAD_W'(1 << GRADIENT_FRAC_BITS);
	localparam logic [ALPHA_BITS-1:0] ALPHA_MAX = ALPHA_BITS'((1 << ALPHA_BITS) - 1);
	localparam logic signed [MINOR_INT_W-1:0] PIX_MAX =
		MINOR_INT_W'((1 << (COORD_INT_BITS - 1)) - 1);
	localparam logic signed [MINOR_INT_W-1:0] PIX_MIN =
		MINOR_INT_W'(-(1 << (COORD_INT_BITS - 1)));

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	typedef struct packed {
		logic                      operation;
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_INT_BITS-1:0] pixel_x;
		logic signed [COORD_INT_BITS-1:0] pixel_y;
		logic                             partner_on_x;
		logic [ALPHA_BITS-1:0]            alpha_near;
		logic [ALPHA_BITS-1:0]            alpha_far;
		logic                             last_pair;
	} result_t;

	typedef struct packed {
		logic                      steep;
		logic signed [GRAD_W-1:0]  grad;
		logic signed [MINOR_W-1:0] minor0;
		logic signed [MINOR_W-1:0] minor1;
		logic signed [MAJOR_W-1:0] major0;
		logic signed [MAJOR_W-1:0] major1;
		logic [GAP_W-1:0]          gap0;
		logic [GAP_W-1:0]          gap1;
	} line_setup_t;

	typedef struct packed {
		logic        is_start;
		line_setup_t setup;
	} cmd_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_ORIENT,
		F_ORDER,
		F_LAUNCH,
		F_DIVIDE,
		F_FINISH
	} front_state_t;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_SECOND,
		PH_INTERIOR
	} phase_t;

	function automatic logic signed [COORD_INT_BITS-1:0] sat_pix(
		input logic signed [MINOR_INT_W-1:0] v);
		logic signed [COORD_INT_BITS-1:0] r;
		if (v > PIX_MAX) begin
			r = PIX_MAX[COORD_INT_BITS-1:0];
		end else if (v < PIX_MIN) begin
			r = PIX_MIN[COORD_INT_BITS-1:0];
		end else begin
			r = v[COORD_INT_BITS-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/alr_div.sv @@
`default_nettype none

module alr_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [alr_pkg::NUM_W-1:0]    numer,
	input  logic [alr_pkg::COORD_W-1:0]  denom,
	output logic                         done,
	output logic [alr_pkg::QUO_W-1:0]    quotient
);
	import alr_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [COORD_W-1:0]   rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic [COORD_W:0]     trial;
	logic [COORD_W:0]     diff;
	logic                 ge;

	// Restoring division: one quotient bit per cycle, the numerator bits
	// shift out of the quotient register as the result bits shift in.
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign diff  = trial - {1'b0, denom};
	assign ge    = trial >= {1'b0, denom};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= DIV_CNT_W'(QUO_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - DIV_CNT_W'(1);
			done_q <= (cnt_q == DIV_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= COORD_W'(numer[NUM_W-1:QUO_W]);
			quo_q <= numer[QUO_W-1:0];
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

@@ rtl/alr_front.sv @@
`default_nettype none

module alr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  alr_pkg::in_item_t item,
	input  logic              push,
	output logic              full,
	output alr_pkg::cmd_t     cmd,
	output logic              cmd_push,
	input  logic              cmd_full
);
	import alr_pkg::*;

	front_state_t state_q, state_d;

	logic signed [COORD_W-1:0] maj0_q, min0_q, maj1_q, min1_q;
	logic                      steep_q;
	logic [COORD_W-1:0]        dx_q, mag_q;
	logic                      dy_neg_q;
	logic signed [GRAD_W-1:0]  grad_q;

	logic signed [COORD_W:0]   dxs, dys, adx_full, ady_full;
	logic [COORD_W-1:0]        adx, ady;
	logic                      swap_ends;
	logic                      div_start, div_done;
	logic [NUM_W-1:0]          numer;
	logic [QUO_W-1:0]          quo;
	logic signed [GRAD_W-1:0]  grad_d;

	logic [COORD_FRAC_BITS-1:0] frac0, frac1;
	logic                       has_frac1;
	logic [GAP_W-1:0]           d1;
	logic signed [PROD_W-1:0]   prod0, prod1, off0, off1;
	logic signed [MINOR_W-1:0]  base0, base1;
	line_setup_t                setup;

	assign dxs      = {maj1_q[COORD_W-1], maj1_q} - {maj0_q[COORD_W-1], maj0_q};
	assign dys      = {min1_q[COORD_W-1], min1_q} - {min0_q[COORD_W-1], min0_q};
	assign adx_full = dxs[COORD_W] ? -dxs : dxs;
	assign ady_full = dys[COORD_W] ? -dys : dys;
	assign adx      = adx_full[COORD_W-1:0];
	assign ady      = ady_full[COORD_W-1:0];
	assign swap_ends = maj0_q > maj1_q;

	assign numer = {mag_q, {GRADIENT_FRAC_BITS{1'b0}}} + NUM_W'(dx_q >> 1);

	alr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (numer),
		.denom    (dx_q),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		if (dx_q == '0) begin
			grad_d = ONE_G;
		end else if (dy_neg_q) begin
			grad_d = -$signed({1'b0, quo});
		end else begin
			grad_d = $signed({1'b0, quo});
		end
	end

	// Endpoint setup once the gradient is known.
	always_comb begin
		frac0     = maj0_q[COORD_FRAC_BITS-1:0];
		frac1     = maj1_q[COORD_FRAC_BITS-1:0];
		has_frac1 = |frac1;
		d1        = has_frac1 ? ONE_C - {1'b0, frac1} : '0;
		prod0     = grad_q * $signed({1'b0, 1'b0, frac0});
		prod1     = grad_q * $signed({1'b0, d1});
		off0      = prod0 >>> COORD_FRAC_BITS;
		off1      = prod1 >>> COORD_FRAC_BITS;
		base0     = {{(MINOR_W - COORD_W - SCALE_SH){min0_q[COORD_W-1]}},
			min0_q, {SCALE_SH{1'b0}}};
		base1     = {{(MINOR_W - COORD_W - SCALE_SH){min1_q[COORD_W-1]}},
			min1_q, {SCALE_SH{1'b0}}};

		setup.steep  = steep_q;
		setup.grad   = grad_q;
		setup.minor0 = base0 - MINOR_W'(off0);
		setup.minor1 = base1 + MINOR_W'(off1);
		setup.major0 = {maj0_q[COORD_W-1], maj0_q[COORD_W-1:COORD_FRAC_BITS]};
		setup.major1 = {maj1_q[COORD_W-1], maj1_q[COORD_W-1:COORD_FRAC_BITS]}
			+ MAJOR_W'(has_frac1);
		setup.gap0   = ONE_C - {1'b0, frac0};
		setup.gap1   = ONE_C - d1;
	end

	assign full = (state_q != F_IDLE) || cmd_full;

	always_comb begin
		state_d      = state_q;
		cmd_push     = 1'b0;
		div_start    = 1'b0;
		cmd.is_start = (state_q == F_FINISH);
		cmd.setup    = setup;
		case (state_q)
			F_IDLE: begin
				if (push && !full) begin
					if (item.operation == OP_START) begin
						state_d = F_ORIENT;
					end else begin
						cmd_push = 1'b1;
					end
				end
			end
			F_ORIENT: state_d = F_ORDER;
			F_ORDER:  state_d = F_LAUNCH;
			F_LAUNCH: begin
				div_start = 1'b1;
				state_d   = F_DIVIDE;
			end
			F_DIVIDE: begin
				if (div_done) begin
					state_d = F_FINISH;
				end
			end
			F_FINISH: begin
				if (!cmd_full) begin
					cmd_push = 1'b1;
					state_d  = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (push && !full && item.operation == OP_START) begin
					maj0_q <= item.start_x;
					min0_q <= item.start_y;
					maj1_q <= item.end_x;
					min1_q <= item.end_y;
				end
			end
			F_ORIENT: begin
				// A steep line walks along y, so the axes trade places.
				steep_q <= ady > adx;
				if (ady > adx) begin
					maj0_q <= min0_q;
					min0_q <= maj0_q;
					maj1_q <= min1_q;
					min1_q <= maj1_q;
				end
			end
			F_ORDER: begin
				dx_q  <= adx;
				mag_q <= ady;
				dy_neg_q <= swap_ends ? (!dys[COORD_W] && (dys != '0)) : dys[COORD_W];
				if (swap_ends) begin
					maj0_q <= maj1_q;
					min0_q <= min1_q;
					maj1_q <= maj0_q;
					min1_q <= min0_q;
				end
			end
			F_DIVIDE: begin
				if (div_done) begin
					grad_q <= grad_d;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/alr_queue.sv @@
`default_nettype none

module alr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  alr_pkg::cmd_t wr_data,
	input  logic          wr_en,
	output logic          full,
	output alr_pkg::cmd_t rd_data,
	input  logic          rd_en,
	output logic          empty
);
	import alr_pkg::*;

	cmd_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               do_wr, do_rd;

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

@@ rtl/alr_back.sv @@
`default_nettype none

module alr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  alr_pkg::cmd_t    cmd,
	input  logic             cmd_empty,
	output logic             cmd_pop,
	output alr_pkg::result_t result,
	output logic             empty,
	input  logic             pop
);
	import alr_pkg::*;

	logic                      busy_q;
	phase_t                    phase_q;
	logic                      out_valid_q;
	result_t                   out_q;

	logic                      steep_q;
	logic signed [GRAD_W-1:0]  grad_q;
	logic signed [MINOR_W-1:0] acc_q, end_minor_q;
	logic signed [MAJOR_W-1:0] pos_q, end_q;
	logic [GAP_W-1:0]          gap0_q, gap1_q;

	logic                      slot_free, emit, load;
	logic signed [MAJOR_W:0]   pos_inc, end_ext;
	logic                      last_col;
	logic signed [MAJOR_W-1:0] sel_col;
	logic signed [MINOR_W-1:0] sel_minor;
	logic [GAP_W-1:0]          sel_gap;
	logic                      sel_last;
	logic signed [MINOR_INT_W-1:0] minor_int, col_ext;
	logic [ALPHA_BITS-1:0]     frac_byte, near_base;
	logic [ALPHA_BITS+GAP_W-1:0] near_prod, far_prod;
	result_t                   pix;

	assign slot_free = !out_valid_q || pop;
	assign cmd_pop   = !cmd_empty && (cmd.is_start || !busy_q || slot_free);
	assign load      = cmd_pop && cmd.is_start;
	// A step that finds no line in progress is dropped without a result.
	assign emit      = cmd_pop && !cmd.is_start && busy_q;

	assign pos_inc  = {pos_q[MAJOR_W-1], pos_q} + (MAJOR_W + 1)'(1);
	assign end_ext  = {end_q[MAJOR_W-1], end_q};
	assign last_col = pos_inc >= end_ext;

	always_comb begin
		case (phase_q)
			PH_FIRST: begin
				sel_col   = pos_q;
				sel_minor = acc_q;
				sel_gap   = gap0_q;
				sel_last  = 1'b0;
			end
			PH_SECOND: begin
				sel_col   = end_q;
				sel_minor = end_minor_q;
				sel_gap   = gap1_q;
				sel_last  = last_col;
			end
			default: begin
				sel_col   = pos_q;
				sel_minor = acc_q;
				sel_gap   = ONE_C;
				sel_last  = last_col;
			end
		endcase
	end

	always_comb begin
		minor_int = sel_minor[MINOR_W-1:GRADIENT_FRAC_BITS];
		col_ext   = MINOR_INT_W'(sel_col);
		frac_byte = sel_minor[GRADIENT_FRAC_BITS-1 -: ALPHA_BITS];
		near_base = ALPHA_MAX - frac_byte;
		near_prod = {{GAP_W{1'b0}}, near_base} * {{ALPHA_BITS{1'b0}}, sel_gap};
		far_prod  = {{GAP_W{1'b0}}, frac_byte} * {{ALPHA_BITS{1'b0}}, sel_gap};

		pix.pixel_x      = steep_q ? sat_pix(minor_int) : sat_pix(col_ext);
		pix.pixel_y      = steep_q ? sat_pix(col_ext) : sat_pix(minor_int);
		pix.partner_on_x = steep_q;
		pix.alpha_near   = near_prod[COORD_FRAC_BITS +: ALPHA_BITS];
		pix.alpha_far    = far_prod[COORD_FRAC_BITS +: ALPHA_BITS];
		pix.last_pair    = sel_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= PH_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end

			if (load) begin
				busy_q  <= 1'b1;
				phase_q <= PH_FIRST;
			end else if (emit) begin
				case (phase_q)
					PH_FIRST: phase_q <= PH_SECOND;
					PH_SECOND: begin
						if (last_col) begin
							busy_q <= 1'b0;
						end else begin
							phase_q <= PH_INTERIOR;
						end
					end
					default: begin
						if (last_col) begin
							busy_q <= 1'b0;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= pix;
		end
		if (load) begin
			steep_q     <= cmd.setup.steep;
			grad_q      <= cmd.setup.grad;
			acc_q       <= cmd.setup.minor0;
			end_minor_q <= cmd.setup.minor1;
			pos_q       <= cmd.setup.major0;
			end_q       <= cmd.setup.major1;
			gap0_q      <= cmd.setup.gap0;
			gap1_q      <= cmd.setup.gap1;
		end else if (emit) begin
			// The second endpoint leaves the interior walk where the first left it.
			if (phase_q != PH_SECOND) begin
				acc_q <= acc_q + MINOR_W'(grad_q);
			end
			if (phase_q != PH_FIRST) begin
				pos_q <= pos_q + MAJOR_W'(1);
			end
		end
	end

	assign result = out_q;
	assign empty  = !out_valid_q;

endmodule

`default_nettype wire

@@ rtl/antialiased_line_rasterizer_core.sv @@
// Antialiased line rasterizer core. A start transaction (operation 0) loads two
// endpoints in signed 12.4 fixed point; each step transaction (operation 1)
// then yields one pixel pair with near and far coverage: the first endpoint
// column, the second endpoint column, then the interior columns in increasing
// order, the final pair carrying last_pair. A step while no line is active
// yields nothing, and a start abandons any line in progress. Steps flow at one
// per cycle through a two-entry command queue into the line walker and its
// output register while each result is popped and no start is in progress. A
// start holds full high for orientation, ordering, divider launch, bit-serial
// gradient division (one quotient bit per cycle, 17 bits) and endpoint setup.
`default_nettype none

module antialiased_line_rasterizer_core (
	input  logic              clk,
	input  logic              arst_n,
	input  alr_pkg::in_item_t item,
	input  logic              push,
	output logic              full,
	output alr_pkg::result_t  result,
	output logic              empty,
	input  logic              pop
);
	import alr_pkg::*;

	cmd_t fq_data, bq_data;
	logic fq_push, q_full, q_empty, q_pop;

	alr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.push     (push),
		.full     (full),
		.cmd      (fq_data),
		.cmd_push (fq_push),
		.cmd_full (q_full)
	);

	alr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_data (fq_data),
		.wr_en   (fq_push),
		.full    (q_full),
		.rd_data (bq_data),
		.rd_en   (q_pop),
		.empty   (q_empty)
	);

	alr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (bq_data),
		.cmd_empty (q_empty),
		.cmd_pop   (q_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

`default_nettype wire

@@ rtl/alr_checker.sv @@
`default_nettype none

module alr_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  alr_pkg::in_item_t item,
	input  logic              push,
	input  logic              full,
	input  alr_pkg::result_t  result,
	input  logic              empty,
	input  logic              pop
);
	import alr_pkg::*;

	// A waiting result must not change until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
	else $error("result changed or vanished while stalled");

	// Coverage of a pair never exceeds full coverage, endpoints included.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ({1'b0, result.alpha_near} + {1'b0, result.alpha_far})
			<= {1'b0, ALPHA_MAX})
	else $error("pair coverage exceeds full scale");

	// Accepting a start occupies the front end while the gradient is formed.
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && item.operation == OP_START |=> full)
	else $error("front end took input right after a start");

	// Ordering and the division follow orientation, so full stays up past the next edge.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) && $past(push) && $past(item.operation) == OP_START |=> full)
	else $error("start released the input too early");

endmodule

bind antialiased_line_rasterizer_core alr_checker u_checker (.*);

`default_nettype wire
